### sv/rc_receiver_frame_decoder_defines.svh
// Assertion macros for the remote-control frame decoder.
// Both expect i_clk and i_rst_n in scope of the module that uses them.
`ifndef RC_RECEIVER_FRAME_DECODER_DEFINES_SVH
`define RC_RECEIVER_FRAME_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define RCFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rcfd: same-cycle check failed");
// next-cycle implication
`define RCFD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rcfd: next-cycle check failed");
`else
`define RCFD_ASSERT_IMP(lbl, ante, cons)
`define RCFD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### sv/rcfd_pkg.sv
package rcfd_pkg;

    localparam int FRAME_LEN       = 25;
    localparam int CHECK_SPLIT     = 18;
    localparam int COUNT_W         = 6;
    localparam int WR_IDX_W        = 5;
    localparam int NUM_STICKS      = 4;
    localparam int OFFSET_W        = 11;
    localparam int CFG_IDX_W       = 3;

    // receive buffer size in bytes; bytes beyond it are dropped
    localparam logic [COUNT_W-1:0] RX_BUFFER_BYTES = 6'd32;
    localparam logic [COUNT_W-1:0] FRAME_BYTES     = 6'd25;

    // item kind carried on tuser
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STICK0_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STICK1_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STICK2_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STICK3_OFFSET = 3'd3;

    // stick center subtracted from every raw channel
    localparam logic [12:0] STICK_CENTER = 13'd1024;

    typedef logic [FRAME_LEN-1:0][7:0]             t_frame;
    typedef logic [NUM_STICKS-1:0][OFFSET_W-1:0]   t_offsets;

    typedef struct packed {
        logic wr;   // store one data byte
        logic clr;  // end of frame: clear store and count
    } t_store_ctl;

    // first listed member sits in the highest bits, so stick0 lands at bit 0
    typedef struct packed {
        logic        [15:0] key_mask;
        logic        [15:0] mouse_buttons;
        logic signed [15:0] mouse_z;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_x;
        logic        [10:0] dial;
        logic        [1:0]  switch_two;
        logic        [1:0]  switch_one;
        logic signed [11:0] stick3;
        logic signed [11:0] stick2;
        logic signed [11:0] stick1;
        logic signed [11:0] stick0;
    } t_result;

endpackage

### sv/rcfd_frame_store.sv
module rcfd_frame_store
    import rcfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_ctl i_ctl,
    input  logic [7:0] i_byte,
    output t_frame     o_frame
);

    t_frame               r_frame;
    logic [COUNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_count <= '0;
        end else if (i_ctl.clr) begin
            r_frame <= '0;
            r_count <= '0;
        end else if (i_ctl.wr && (r_count < RX_BUFFER_BYTES)) begin
            // bytes past the frame length are counted but not kept
            if (r_count < FRAME_BYTES) begin
                r_frame[r_count[WR_IDX_W-1:0]] <= i_byte;
            end
            r_count <= r_count + 1'b1;
        end
    end

    assign o_frame = r_frame;

endmodule

### sv/rcfd_unpack.sv
module rcfd_unpack
    import rcfd_pkg::*;
(
    input  t_frame   i_frame,
    input  t_offsets i_offsets,
    output logic     o_frame_ok,
    output t_result  o_result
);

    logic [NUM_STICKS-1:0][10:0] w_raw;
    logic [NUM_STICKS-1:0][12:0] w_diff;
    logic                        w_any_head;
    logic                        w_any_tail;

    always_comb begin
        w_any_head = 1'b0;
        w_any_tail = 1'b0;
        for (int i = 0; i < CHECK_SPLIT; i++) begin
            w_any_head = w_any_head | (|i_frame[i]);
        end
        for (int i = CHECK_SPLIT; i < FRAME_LEN; i++) begin
            w_any_tail = w_any_tail | (|i_frame[i]);
        end
    end

    assign o_frame_ok = w_any_head && !w_any_tail;

    // 11-bit channels packed across bytes 0..5
    assign w_raw[0] = {i_frame[1][2:0], i_frame[0]};
    assign w_raw[1] = {i_frame[2][5:0], i_frame[1][7:3]};
    assign w_raw[2] = {i_frame[4][0],   i_frame[3], i_frame[2][7:6]};
    assign w_raw[3] = {i_frame[5][3:0], i_frame[4][7:1]};

    always_comb begin
        for (int c = 0; c < NUM_STICKS; c++) begin
            w_diff[c] = {2'b00, w_raw[c]} - STICK_CENTER
                      - {{2{i_offsets[c][OFFSET_W-1]}}, i_offsets[c]};
        end
    end

    assign o_result.stick0        = w_diff[0][11:0];
    assign o_result.stick1        = w_diff[1][11:0];
    assign o_result.stick2        = w_diff[2][11:0];
    assign o_result.stick3        = w_diff[3][11:0];
    assign o_result.switch_one    = i_frame[5][7:6];
    assign o_result.switch_two    = i_frame[5][5:4];
    assign o_result.dial          = {i_frame[17][2:0], i_frame[16]};
    assign o_result.mouse_x       = {i_frame[7],  i_frame[6]};
    assign o_result.mouse_y       = {i_frame[9],  i_frame[8]};
    assign o_result.mouse_z       = {i_frame[11], i_frame[10]};
    assign o_result.mouse_buttons = {i_frame[13], i_frame[12]};
    assign o_result.key_mask      = {i_frame[15], i_frame[14]};

endmodule

### sv/rc_receiver_frame_decoder.sv
// Remote-control receiver frame decoder.
// Slave stream: one request per received byte. tuser = 0 carries a data byte
// in tdata; tuser = 1 marks line idle (end of frame) and tdata is ignored.
// Data bytes fill a 25-byte frame store in arrival order; bytes beyond the
// 32-byte receive buffer are dropped. On idle the frame is checked (bytes
// 0..17 not all zero, bytes 18..24 all zero); a good frame yields one master
// stream request with the unpacked sticks, switches, dial, mouse and keys,
// a bad frame yields nothing. Either way the store and count are cleared.
// Config channel: writes stick rest offsets, index 0..3; other indexes are
// accepted and ignored. Always ready. Write only while the stream is quiet.
// The result of an idle request passes the input register, then the output
// register, before it is valid on the master side.
// Throughput: one request per cycle unless stalled (see below), set by the
// store update and unpack between the input and output registers.
// Stall: while the output register holds an untaken result and the input
// register holds an idle that would produce another, s_axis_tready drops.
// Reset (synchronous, active low) clears both registers' valid flags, the
// frame store, the byte count and all offsets.
`include "rc_receiver_frame_decoder_defines.svh"
module rc_receiver_frame_decoder
    import rcfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    input  logic                 s_axis_tuser,   // [0] op
    // master stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [11:0] stick0, [23:12] stick1, [35:24] stick2, [47:36] stick3,
    // [49:48] switch_one, [51:50] switch_two, [62:52] dial,
    // [78:63] mouse_x, [94:79] mouse_y, [110:95] mouse_z,
    // [126:111] mouse_buttons, [142:127] key_mask, [143] zero
    output logic [143:0]         m_axis_tdata,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [OFFSET_W-1:0]  i_cfg_data
);

    // input register
    logic        r_in_vld;
    logic        r_op;
    logic [7:0]  r_byte;

    // output register
    logic        r_out_vld;
    t_result     r_out;

    t_offsets    r_offsets;

    t_frame      w_frame;
    t_result     w_result;
    logic        w_frame_ok;
    logic        w_out_free;
    logic        w_adv;
    logic        w_emit;
    t_store_ctl  w_ctl;

    assign w_out_free = !r_out_vld || m_axis_tready;
    // a data byte or a rejected frame never needs the output slot
    assign w_adv  = r_in_vld && ((r_op == OP_DATA) || !w_frame_ok || w_out_free);
    assign w_emit = w_adv && (r_op == OP_IDLE) && w_frame_ok;

    assign s_axis_tready = !r_in_vld || w_adv;

    assign w_ctl.wr  = w_adv && (r_op == OP_DATA);
    assign w_ctl.clr = w_adv && (r_op == OP_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_op   <= s_axis_tuser;
            r_byte <= s_axis_tdata;
        end
    end

    rcfd_frame_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_byte  (r_byte),
        .o_frame (w_frame)
    );

    rcfd_unpack u_unpack (
        .i_frame    (w_frame),
        .i_offsets  (r_offsets),
        .o_frame_ok (w_frame_ok),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out};

    // config writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offsets <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_STICK0_OFFSET: r_offsets[0] <= i_cfg_data;
                REG_STICK1_OFFSET: r_offsets[1] <= i_cfg_data;
                REG_STICK2_OFFSET: r_offsets[2] <= i_cfg_data;
                REG_STICK3_OFFSET: r_offsets[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a good frame always lands in the output register
    `RCFD_ASSERT_NXT(a_emit_lands, w_emit, r_out_vld)
    // end of frame leaves an empty store, which can never pass the check
    `RCFD_ASSERT_NXT(a_idle_clears, w_ctl.clr, !w_frame_ok)
    // backpressure only comes from a full output register
    `RCFD_ASSERT_IMP(a_stall_cause, !s_axis_tready, r_in_vld && r_out_vld && !m_axis_tready)
    // a stalled input item is not lost
    `RCFD_ASSERT_NXT(a_hold_input, r_in_vld && !w_adv, r_in_vld)

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb
    import rcfd_pkg::*;
();

    localparam int STALL_LIMIT = 3000;  // cycles with no handshake at all
    localparam int LONG_HOLD   = 400;   // one long sink hold-off, fills the pipe
    localparam int DRAIN_WAIT  = 4;     // margin for results to leave both registers

    // one slave-side request: a data byte or an idle marker
    typedef struct {
        logic       op;
        logic [7:0] data;
        bit         drain_first;    // hold this request until all results are in
    } t_rx_req;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic                 s_axis_tuser = OP_DATA; // [0] op
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [143:0]         m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [OFFSET_W-1:0]  i_cfg_data = '0;

    rc_receiver_frame_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // requests waiting to be offered, and decoded frames waiting to come out
    t_rx_req    req_q [$];
    t_result    decoded_q [$];
    logic [7:0] frame_buf [$];

    // shadow of the decoder state
    logic [7:0]          frame_store [FRAME_LEN];
    logic [COUNT_W-1:0]  rx_count;
    logic [OFFSET_W-1:0] stick_offs [NUM_STICKS];

    // traffic shaping, set per phase
    int  src_gap_pct = 0;
    int  sink_stall_pct = 0;
    bit  calm = 0;

    int      n_fail = 0;
    int      results_seen = 0;
    int      src_gap_left = 0;
    int      sink_hold_left = 0;
    bit      long_hold_done = 0;
    int      quiet_cycles = 0;
    t_rx_req next_req;

    // raw 11-bit channel, centered and trimmed by a signed rest offset
    function automatic logic [11:0] center_stick(input logic [10:0] raw,
                                                 input logic [10:0] off);
        int v;
        v = int'(raw) - int'(STICK_CENTER) - int'($signed(off));
        return v[11:0];
    endfunction

    // good frame: something in bytes 0..17, nothing in 18..24
    function automatic bit frame_passes();
        bit head_live;
        bit tail_clear;
        head_live = 0;
        tail_clear = 1;
        for (int i = 0; i < CHECK_SPLIT; i++)
            if (frame_store[i] != 8'h00) head_live = 1;
        for (int i = CHECK_SPLIT; i < FRAME_LEN; i++)
            if (frame_store[i] != 8'h00) tail_clear = 0;
        return head_live && tail_clear;
    endfunction

    function automatic t_result decode_frame();
        t_result r;
        r.stick0 = center_stick({frame_store[1][2:0], frame_store[0]}, stick_offs[0]);
        r.stick1 = center_stick({frame_store[2][5:0], frame_store[1][7:3]}, stick_offs[1]);
        r.stick2 = center_stick({frame_store[4][0], frame_store[3], frame_store[2][7:6]},
                                stick_offs[2]);
        r.stick3 = center_stick({frame_store[5][3:0], frame_store[4][7:1]}, stick_offs[3]);
        r.switch_one    = frame_store[5][7:6];
        r.switch_two    = frame_store[5][5:4];
        r.dial          = {frame_store[17][2:0], frame_store[16]};
        r.mouse_x       = {frame_store[7], frame_store[6]};
        r.mouse_y       = {frame_store[9], frame_store[8]};
        r.mouse_z       = {frame_store[11], frame_store[10]};
        r.mouse_buttons = {frame_store[13], frame_store[12]};
        r.key_mask      = {frame_store[15], frame_store[14]};
        return r;
    endfunction

    function automatic void clear_frame();
        foreach (frame_store[i]) frame_store[i] = 8'h00;
        rx_count = '0;
    endfunction

    // update the shadow state with one accepted request
    function automatic void absorb_request(input logic op, input logic [7:0] data);
        if (op == OP_DATA) begin
            // past the receive buffer the byte is dropped; past the frame it is
            // counted but not kept
            if (rx_count < RX_BUFFER_BYTES) begin
                if (rx_count < FRAME_BYTES) frame_store[rx_count] = data;
                rx_count = rx_count + 1'b1;
            end
        end else begin
            if (frame_passes()) decoded_q.push_back(decode_frame());
            clear_frame();
        end
    endfunction

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            n_fail++;
        end
    endtask

    task automatic check_result(input logic [143:0] data);
        t_result want;
        t_result got;
        got = t_result'(data[142:0]);
        if (decoded_q.size() == 0) begin
            $error("result with no frame pending: tdata %h", data);
            n_fail++;
        end else begin
            want = decoded_q.pop_front();
            check_field("stick0", int'(want.stick0), int'(got.stick0));
            check_field("stick1", int'(want.stick1), int'(got.stick1));
            check_field("stick2", int'(want.stick2), int'(got.stick2));
            check_field("stick3", int'(want.stick3), int'(got.stick3));
            check_field("switch_one", int'(want.switch_one), int'(got.switch_one));
            check_field("switch_two", int'(want.switch_two), int'(got.switch_two));
            check_field("dial", int'(want.dial), int'(got.dial));
            check_field("mouse_x", int'(want.mouse_x), int'(got.mouse_x));
            check_field("mouse_y", int'(want.mouse_y), int'(got.mouse_y));
            check_field("mouse_z", int'(want.mouse_z), int'(got.mouse_z));
            check_field("mouse_buttons", int'(want.mouse_buttons), int'(got.mouse_buttons));
            check_field("key_mask", int'(want.key_mask), int'(got.key_mask));
            check_field("pad", 0, int'(data[143]));
        end
    endtask

    // source side: offers queued requests, with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) absorb_request(s_axis_tuser, s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap_left > 0) begin
                    src_gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 99) < src_gap_pct) begin
                    src_gap_left = $urandom_range(0, 7);
                    s_axis_tvalid <= 1'b0;
                end else if (req_q.size() != 0 &&
                             !(req_q[0].drain_first && decoded_q.size() != 0)) begin
                    next_req = req_q.pop_front();
                    s_axis_tdata  <= next_req.data;
                    s_axis_tuser  <= next_req.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side: checks results, stalls in bursts, and once holds off long
    // enough that the output and input registers both fill up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
                results_seen++;
            end
            if (sink_hold_left > 0) begin
                sink_hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!long_hold_done && !calm && results_seen >= 5 && m_axis_tvalid) begin
                long_hold_done = 1;
                sink_hold_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < sink_stall_pct) begin
                sink_hold_left = $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: no handshake on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_item(input logic op, input logic [7:0] data, input bit drain);
        t_rx_req r;
        r.op = op;
        r.data = data;
        r.drain_first = drain;
        req_q.push_back(r);
    endtask

    // frame_buf as data requests, closed by an idle
    task automatic queue_frame(input bit drain);
        foreach (frame_buf[i]) push_item(OP_DATA, frame_buf[i], drain && i == 0);
        push_item(OP_IDLE, 8'($urandom_range(0, 255)), drain && frame_buf.size() == 0);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // full-scale sticks/fields, then all sticks at raw zero (switches up)
    task automatic queue_extremes();
        frame_buf.delete();
        repeat (CHECK_SPLIT) frame_buf.push_back(8'hFF);
        queue_frame(0);
        frame_buf.delete();
        repeat (CHECK_SPLIT) frame_buf.push_back(8'h00);
        frame_buf[5] = 8'hF0;
        queue_frame(0);
    endtask

    // mostly well-formed frames with random content; the rest is dirty tails,
    // dead heads, bare idles and raw noise
    task automatic run_traffic(input int n_items, input int n_good);
        int  items;
        int  goods;
        int  kind;
        int  len;
        int  pos;
        bit  head_live;
        items = 0;
        goods = 0;
        while (items < n_items || goods < n_good) begin
            kind = $urandom_range(0, 99);
            frame_buf.delete();
            if (kind < 83) begin
                // overlong frames run past the store, and some past the buffer
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(26, 40)
                                                  : $urandom_range(18, 25);
                if (kind >= 75 && len < 19) len = 19;
                for (pos = 0; pos < len; pos++)
                    frame_buf.push_back((pos < CHECK_SPLIT || pos >= FRAME_LEN) ?
                                        pick_byte() : 8'h00);
                head_live = 0;
                for (pos = 0; pos < CHECK_SPLIT; pos++)
                    if (frame_buf[pos] != 8'h00) head_live = 1;
                if (!head_live) frame_buf[$urandom_range(0, CHECK_SPLIT - 1)] = 8'h01;
                if (kind >= 75) begin
                    // dirty tail: one nonzero byte among 18..24, frame rejected
                    pos = $urandom_range(CHECK_SPLIT, (len < FRAME_LEN ? len : FRAME_LEN) - 1);
                    frame_buf[pos] = 8'($urandom_range(1, 255));
                end else begin
                    goods++;
                end
            end else if (kind < 89) begin
                // dead head: short or full frame of zeros
                len = $urandom_range(0, FRAME_LEN);
                repeat (len) frame_buf.push_back(8'h00);
            end else if (kind < 93) begin
                len = 0;
            end else begin
                len = $urandom_range(1, 40);
                repeat (len)
                    push_item(($urandom_range(0, 15) == 0) ? OP_IDLE : OP_DATA,
                              8'($urandom_range(0, 255)), 0);
                items += len;
                continue;
            end
            queue_frame($urandom_range(0, 19) == 0);
            items += len + 1;
        end
    endtask

    // all requests taken and every decoded frame out, then the pipe settles
    task automatic wait_quiet();
        @(posedge i_clk);
        while (req_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // writes back to back on the config channel; spare indexes must be ignored
    task automatic write_offsets(input logic [OFFSET_W-1:0] o0, o1, o2, o3,
                                 input bit spare);
        logic [CFG_IDX_W-1:0] idx [$];
        logic [OFFSET_W-1:0]  val [$];
        idx.push_back(REG_STICK0_OFFSET); val.push_back(o0);
        idx.push_back(REG_STICK1_OFFSET); val.push_back(o1);
        if (spare) begin
            for (int k = 1; k <= 4; k++) begin
                idx.push_back(CFG_IDX_W'(REG_STICK3_OFFSET + k));
                val.push_back(OFFSET_W'($urandom_range(0, 2047)));
            end
        end
        idx.push_back(REG_STICK2_OFFSET); val.push_back(o2);
        idx.push_back(REG_STICK3_OFFSET); val.push_back(o3);
        for (int k = 0; k < idx.size(); k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            if (idx[k] <= REG_STICK3_OFFSET) stick_offs[idx[k]] = val[k];
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        clear_frame();
        foreach (stick_offs[i]) stick_offs[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset offsets: idle on an empty store, an 18-byte all-ones
        // frame, a one-byte frame padded by the cleared store, a second idle
        push_item(OP_IDLE, 8'hA5, 0);
        repeat (CHECK_SPLIT) push_item(OP_DATA, 8'hFF, 0);
        push_item(OP_IDLE, 8'h5A, 0);
        push_item(OP_DATA, 8'h01, 0);
        push_item(OP_IDLE, 8'h00, 0);
        push_item(OP_IDLE, 8'hFF, 0);

        // most negative offsets, both sides idling; the long hold lands here
        wait_quiet();
        write_offsets(11'h400, 11'h400, 11'h400, 11'h400, 0);
        src_gap_pct = 20;
        sink_stall_pct = 20;
        queue_extremes();
        run_traffic(230, 6);

        // most positive offsets, spare indexes written, source never idles
        wait_quiet();
        write_offsets(11'h3FF, 11'h3FF, 11'h3FF, 11'h3FF, 1);
        src_gap_pct = 0;
        sink_stall_pct = 40;
        queue_extremes();
        run_traffic(230, 6);

        // random offsets, sink never stalls
        wait_quiet();
        write_offsets(OFFSET_W'($urandom_range(0, 2047)), OFFSET_W'($urandom_range(0, 2047)),
                      OFFSET_W'($urandom_range(0, 2047)), OFFSET_W'($urandom_range(0, 2047)),
                      1);
        src_gap_pct = 40;
        sink_stall_pct = 0;
        queue_extremes();
        run_traffic(230, 6);

        // closing stretch at full rate on both sides
        wait_quiet();
        write_offsets(11'h000, 11'h7FF, OFFSET_W'($urandom_range(0, 2047)), 11'h001, 0);
        calm = 1;
        queue_extremes();
        run_traffic(130, 4);

        wait_quiet();
        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/rcfd_pkg.sv
sv/rcfd_frame_store.sv
sv/rcfd_unpack.sv
sv/rc_receiver_frame_decoder.sv
tb/sv/tb.sv
